// File: rtl/bb3_pkg.sv
package bb3_pkg;

  // Frame geometry
  localparam int MAX_WIDTH = 2048;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int FW_W      = 12;
  localparam int FH_W      = 16;
  localparam int COL_W     = 11;
  localparam int ROW_W     = 16;
  localparam int CH_W      = 8;
  localparam int PIX_W     = 3 * CH_W;
  localparam int LINE_W    = 2 * PIX_W;

  // Sum of nine 8-bit samples, and floor(sum / 9) as multiply by reciprocal
  localparam int SUM_W     = 12;
  localparam int RECIP_W   = 13;
  localparam int PROD_W    = SUM_W + RECIP_W;
  localparam int RECIP_SH  = 16;
  localparam logic [RECIP_W-1:0] RECIP9 = RECIP_W'(7282);

  // Queue between front and back
  localparam int QDEPTH    = 8;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = QPTR_W + 1;

  // Configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);
  localparam logic [FW_W-1:0] FW_RESET = FW_W'(640);
  localparam logic [FH_W-1:0] FH_RESET = FH_W'(480);

  // One classified input transaction, ready for emission
  typedef struct packed {
    logic [PIX_W-1:0] mean_px;   // value for pixel (r-1, c-1)
    logic [PIX_W-1:0] edge_px;   // value for pixel (r-1, width-1)
    logic [PIX_W-1:0] pass_px;   // incoming pixel itself
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             emit_inner;
    logic             emit_edge;
    logic             emit_last_row;
    logic             last_col;
  } entry_t;

endpackage

// File: rtl/bb3_front.sv
module bb3_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [bb3_pkg::CH_W-1:0] red_in,
  input  logic [bb3_pkg::CH_W-1:0] green_in,
  input  logic [bb3_pkg::CH_W-1:0] blue_in,
  input  logic [bb3_pkg::FW_W-1:0] frame_width,
  input  logic [bb3_pkg::FH_W-1:0] frame_height,
  input  logic                    pop,
  output logic                    push_valid,
  output bb3_pkg::entry_t         push_entry
);

  localparam int AW = bb3_pkg::ADDR_W;
  localparam int PW = bb3_pkg::PIX_W;
  localparam int CW = bb3_pkg::CH_W;
  localparam int SW = bb3_pkg::SUM_W;

  // Line store: {upper row, middle row} per column
  logic [bb3_pkg::LINE_W-1:0] line_mem [bb3_pkg::MAX_WIDTH];

  // Clearing pass after reset
  logic          clearing_r, clearing_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;

  // Position counters
  logic [bb3_pkg::COL_W-1:0] col_r, col_nxt;
  logic [bb3_pkg::ROW_W-1:0] row_r, row_nxt;

  // Credits: transactions in the pipeline plus the queue
  logic [bb3_pkg::QCNT_W-1:0] credit_r, credit_nxt;

  logic [bb3_pkg::FW_W-1:0] w_eff;
  logic [bb3_pkg::FH_W-1:0] h_eff;
  logic                     col_over;
  logic [bb3_pkg::ROW_W:0]  row_t;
  logic [bb3_pkg::ROW_W-1:0] r_cur;
  logic [bb3_pkg::COL_W-1:0] c_cur;
  logic [bb3_pkg::FW_W-1:0] c_inc;
  logic [bb3_pkg::ROW_W:0]  r_inc;
  logic                     accept;
  logic                     cur_last_col;
  logic                     cur_last_row;

  // Stage A: line store read data
  logic                      a_valid_r;
  logic [PW-1:0]             a_px_r;
  logic [bb3_pkg::ROW_W-1:0] a_row_r;
  logic [bb3_pkg::COL_W-1:0] a_col_r;
  logic                      a_inner_r, a_edge_r, a_lrow_r, a_lcol_r, a_mean_r;
  logic [bb3_pkg::LINE_W-1:0] rd_q_r;
  logic                      fwd_r;
  logic [bb3_pkg::LINE_W-1:0] fwd_data_r;
  logic [bb3_pkg::LINE_W-1:0] line_cur;
  logic [bb3_pkg::LINE_W-1:0] line_wr;

  // Stage B: window updated
  logic [PW-1:0]             win_r [9];
  logic                      b_valid_r;
  logic [bb3_pkg::ROW_W-1:0] b_row_r;
  logic [bb3_pkg::COL_W-1:0] b_col_r;
  logic                      b_inner_r, b_edge_r, b_lrow_r, b_lcol_r, b_mean_r;

  // Stage C: per-channel sums
  logic                      c_valid_r;
  logic [bb3_pkg::ROW_W-1:0] c_row_r;
  logic [bb3_pkg::COL_W-1:0] c_col_r;
  logic                      c_inner_r, c_edge_r, c_lrow_r, c_lcol_r, c_mean_r;
  logic [SW-1:0]             c_sum_r [3];
  logic [PW-1:0]             c_win4_r, c_win5_r, c_px_r;
  logic [SW-1:0]             sum_w [3];
  logic [PW-1:0]             quot;

  logic                      mem_we;
  logic [AW-1:0]             mem_wa;
  logic [bb3_pkg::LINE_W-1:0] mem_wd;

  // Effective geometry and position of the incoming transaction
  always_comb begin
    if (frame_width == '0) begin
      w_eff = bb3_pkg::FW_W'(1);
    end else if (frame_width > bb3_pkg::FW_W'(bb3_pkg::MAX_WIDTH)) begin
      w_eff = bb3_pkg::FW_W'(bb3_pkg::MAX_WIDTH);
    end else begin
      w_eff = frame_width;
    end
    h_eff = (frame_height == '0) ? bb3_pkg::FH_W'(1) : frame_height;

    col_over = {1'b0, col_r} >= w_eff;
    row_t    = {1'b0, row_r} + {{bb3_pkg::ROW_W{1'b0}}, col_over};
    r_cur    = (row_t >= {1'b0, h_eff}) ? '0 : row_t[bb3_pkg::ROW_W-1:0];
    c_cur    = col_over ? '0 : col_r;
    c_inc    = {1'b0, c_cur} + bb3_pkg::FW_W'(1);
    r_inc    = {1'b0, r_cur} + (bb3_pkg::ROW_W+1)'(1);

    cur_last_col = ({1'b0, c_cur} == (w_eff - bb3_pkg::FW_W'(1)));
    cur_last_row = (r_cur == (h_eff - bb3_pkg::FH_W'(1)));

    if (c_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = (r_inc >= {1'b0, h_eff}) ? '0 : r_inc[bb3_pkg::ROW_W-1:0];
    end else begin
      col_nxt = c_inc[bb3_pkg::COL_W-1:0];
      row_nxt = r_cur;
    end
  end

  assign in_stall = clearing_r || (credit_r == bb3_pkg::QCNT_W'(bb3_pkg::QDEPTH));
  assign accept   = in_valid && !in_stall;

  // Credit count and clearing sweep
  always_comb begin
    credit_nxt = credit_r;
    if (accept && !pop) begin
      credit_nxt = credit_r + bb3_pkg::QCNT_W'(1);
    end else if (!accept && pop) begin
      credit_nxt = credit_r - bb3_pkg::QCNT_W'(1);
    end
    clearing_nxt = clearing_r;
    clr_addr_nxt = clr_addr_r;
    if (clearing_r) begin
      clr_addr_nxt = clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(bb3_pkg::MAX_WIDTH - 1)) begin
        clearing_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
      credit_r   <= '0;
      col_r      <= '0;
      row_r      <= '0;
    end else begin
      clearing_r <= clearing_nxt;
      clr_addr_r <= clr_addr_nxt;
      credit_r   <= credit_nxt;
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  // Line store contents, corrected for a write still in flight
  assign line_cur = fwd_r ? fwd_data_r : rd_q_r;
  assign line_wr  = {line_cur[PW-1:0], a_px_r};

  assign mem_we = clearing_r || a_valid_r;
  assign mem_wa = clearing_r ? clr_addr_r : a_col_r;
  assign mem_wd = clearing_r ? '0 : line_wr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_q_r <= line_mem[c_cur];
    end
  end

  // Stage A
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_px_r     <= {red_in, green_in, blue_in};
      a_row_r    <= r_cur;
      a_col_r    <= c_cur;
      a_inner_r  <= (r_cur != '0) && (c_cur != '0);
      a_edge_r   <= (r_cur != '0) && cur_last_col;
      a_lrow_r   <= cur_last_row;
      a_lcol_r   <= cur_last_col;
      a_mean_r   <= (r_cur >= bb3_pkg::ROW_W'(2)) && (c_cur >= bb3_pkg::COL_W'(2));
      fwd_r      <= a_valid_r && (a_col_r == c_cur);
      fwd_data_r <= line_wr;
    end
  end

  // Stage B: window shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      b_valid_r <= a_valid_r;
      if (a_valid_r) begin
        for (int k = 0; k < 3; k++) begin
          win_r[k*3]   <= win_r[k*3+1];
          win_r[k*3+1] <= win_r[k*3+2];
        end
        win_r[2] <= line_cur[2*PW-1:PW];
        win_r[5] <= line_cur[PW-1:0];
        win_r[8] <= a_px_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid_r) begin
      b_row_r   <= a_row_r;
      b_col_r   <= a_col_r;
      b_inner_r <= a_inner_r;
      b_edge_r  <= a_edge_r;
      b_lrow_r  <= a_lrow_r;
      b_lcol_r  <= a_lcol_r;
      b_mean_r  <= a_mean_r;
    end
  end

  // Per-channel sum over the window
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum_w[ch] = '0;
      for (int k = 0; k < 9; k++) begin
        sum_w[ch] = sum_w[ch] + SW'(win_r[k][ch*CW +: CW]);
      end
    end
  end

  // Stage C
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else begin
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid_r) begin
      for (int ch = 0; ch < 3; ch++) begin
        c_sum_r[ch] <= sum_w[ch];
      end
      c_win4_r  <= win_r[4];
      c_win5_r  <= win_r[5];
      c_px_r    <= win_r[8];
      c_row_r   <= b_row_r;
      c_col_r   <= b_col_r;
      c_inner_r <= b_inner_r;
      c_edge_r  <= b_edge_r;
      c_lrow_r  <= b_lrow_r;
      c_lcol_r  <= b_lcol_r;
      c_mean_r  <= b_mean_r;
    end
  end

  // floor(sum / 9) by reciprocal; exact for sums up to 9 * 255
  always_comb begin
    logic [bb3_pkg::PROD_W-1:0] prod;
    for (int ch = 0; ch < 3; ch++) begin
      prod = bb3_pkg::PROD_W'(c_sum_r[ch]) * bb3_pkg::PROD_W'(bb3_pkg::RECIP9);
      quot[ch*CW +: CW] = prod[bb3_pkg::RECIP_SH +: CW];
    end
  end

  assign push_valid               = c_valid_r;
  assign push_entry.mean_px       = c_mean_r ? quot : c_win4_r;
  assign push_entry.edge_px       = c_win5_r;
  assign push_entry.pass_px       = c_px_r;
  assign push_entry.row           = c_row_r;
  assign push_entry.col           = c_col_r;
  assign push_entry.emit_inner    = c_inner_r;
  assign push_entry.emit_edge     = c_edge_r;
  assign push_entry.emit_last_row = c_lrow_r;
  assign push_entry.last_col      = c_lcol_r;

endmodule

// File: rtl/bb3_queue.sv
module bb3_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  input  bb3_pkg::entry_t push_entry,
  input  logic            pop,
  output logic            head_valid,
  output bb3_pkg::entry_t head_entry
);

  bb3_pkg::entry_t                ent_r [bb3_pkg::QDEPTH];
  logic [bb3_pkg::QPTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [bb3_pkg::QCNT_W-1:0]     count_r, count_nxt;

  assign head_valid = (count_r != '0);
  assign head_entry = ent_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push_valid && !pop) begin
      count_nxt = count_r + bb3_pkg::QCNT_W'(1);
    end else if (!push_valid && pop) begin
      count_nxt = count_r - bb3_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push_valid) begin
        wr_ptr_r <= wr_ptr_r + bb3_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + bb3_pkg::QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid) begin
      ent_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// File: rtl/bb3_back.sv
module bb3_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      head_valid,
  input  bb3_pkg::entry_t           head_entry,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [bb3_pkg::CH_W-1:0]  out_red_out,
  output logic [bb3_pkg::CH_W-1:0]  out_green_out,
  output logic [bb3_pkg::CH_W-1:0]  out_blue_out,
  output logic [bb3_pkg::ROW_W-1:0] out_row,
  output logic [bb3_pkg::COL_W-1:0] out_col,
  output logic                      out_run_last,
  output logic                      out_frame_done
);

  localparam int CW = bb3_pkg::CH_W;

  logic [2:0] done_r, done_nxt;
  logic [2:0] pend, sel, rest;
  logic       out_free, load, is_last;
  logic       out_valid_r, out_valid_nxt;

  logic [bb3_pkg::PIX_W-1:0] px_nxt, px_r;
  logic [bb3_pkg::ROW_W-1:0] row_nxt, row_r;
  logic [bb3_pkg::COL_W-1:0] col_nxt, col_r;
  logic                      last_r, fdone_r, fdone_nxt;

  // Pick the next outstanding result of the head transaction
  always_comb begin
    pend = {head_entry.emit_last_row, head_entry.emit_edge, head_entry.emit_inner} & ~done_r;
    if (pend[0]) begin
      sel = 3'b001;
    end else if (pend[1]) begin
      sel = 3'b010;
    end else begin
      sel = pend & 3'b100;
    end
    rest     = pend & ~sel;
    is_last  = (rest == '0);
    out_free = !out_valid_r || !out_stall;

    load     = 1'b0;
    pop      = 1'b0;
    done_nxt = done_r;
    if (head_valid) begin
      if (pend == '0) begin
        pop      = 1'b1;
        done_nxt = '0;
      end else if (out_free) begin
        load = 1'b1;
        if (is_last) begin
          pop      = 1'b1;
          done_nxt = '0;
        end else begin
          done_nxt = done_r | sel;
        end
      end
    end

    case (sel)
      3'b001: begin
        px_nxt    = head_entry.mean_px;
        row_nxt   = head_entry.row - bb3_pkg::ROW_W'(1);
        col_nxt   = head_entry.col - bb3_pkg::COL_W'(1);
        fdone_nxt = 1'b0;
      end
      3'b010: begin
        px_nxt    = head_entry.edge_px;
        row_nxt   = head_entry.row - bb3_pkg::ROW_W'(1);
        col_nxt   = head_entry.col;
        fdone_nxt = 1'b0;
      end
      default: begin
        px_nxt    = head_entry.pass_px;
        row_nxt   = head_entry.row;
        col_nxt   = head_entry.col;
        fdone_nxt = head_entry.last_col;
      end
    endcase

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_free) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load) begin
      px_r    <= px_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      last_r  <= is_last;
      fdone_r <= fdone_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red_out    = px_r[2*CW +: CW];
  assign out_green_out  = px_r[CW +: CW];
  assign out_blue_out   = px_r[0 +: CW];
  assign out_row        = row_r;
  assign out_col        = col_r;
  assign out_run_last   = last_r;
  assign out_frame_done = fdone_r;

endmodule

// File: rtl/rgb_box_blur_3x3_unit.sv
// 3x3 box blur on an RGB pixel stream.
// Input channel (in_valid / in_stall): one pixel per transaction, raster
// order, frame geometry from the frame_width and frame_height registers.
// Output channel (out_valid / out_stall): zero to three results per input
// pixel, each with its row and column; out_run_last marks the last result
// of an input, out_frame_done the bottom-right pixel of the frame.
// Config channel (cfg_valid / cfg_ready, always ready): index 0 writes
// frame_width, index 1 frame_height; write only while the block is idle.
// Throughput: one input pixel per cycle while the credits allow; inputs on
// the last row produce up to three results and the output register drains one
// per cycle, so there the input is accepted more slowly. The line store read,
// a window shift and the sum/reciprocal stages are fully pipelined.
// Path: a result passes stage A (line store read), stage B (window), stage C
// (sums), the queue and the output register.
// Reset: a clearing pass over all 2048 entries zeroes the line store; in_stall is
// high throughout. Configuration writes are taken during the pass.
// A stall on the output backs up into the 8-entry queue; in_stall rises once eight transactions are in flight.
module rgb_box_blur_3x3_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [bb3_pkg::CH_W-1:0]       in_red_in,
  input  logic [bb3_pkg::CH_W-1:0]       in_green_in,
  input  logic [bb3_pkg::CH_W-1:0]       in_blue_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [bb3_pkg::CH_W-1:0]       out_red_out,
  output logic [bb3_pkg::CH_W-1:0]       out_green_out,
  output logic [bb3_pkg::CH_W-1:0]       out_blue_out,
  output logic [bb3_pkg::ROW_W-1:0]      out_row,
  output logic [bb3_pkg::COL_W-1:0]      out_col,
  output logic                           out_run_last,
  output logic                           out_frame_done,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bb3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bb3_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [bb3_pkg::FW_W-1:0] frame_width_r;
  logic [bb3_pkg::FH_W-1:0] frame_height_r;

  logic            push_valid, head_valid, pop;
  bb3_pkg::entry_t push_entry, head_entry;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= bb3_pkg::FW_RESET;
      frame_height_r <= bb3_pkg::FH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == bb3_pkg::CFG_FRAME_WIDTH) begin
        frame_width_r <= cfg_data[bb3_pkg::FW_W-1:0];
      end else if (cfg_index == bb3_pkg::CFG_FRAME_HEIGHT) begin
        frame_height_r <= cfg_data[bb3_pkg::FH_W-1:0];
      end
    end
  end

  bb3_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .red_in       (in_red_in),
    .green_in     (in_green_in),
    .blue_in      (in_blue_in),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .pop          (pop),
    .push_valid   (push_valid),
    .push_entry   (push_entry)
  );

  bb3_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  bb3_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (head_valid),
    .head_entry     (head_entry),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_red_out    (out_red_out),
    .out_green_out  (out_green_out),
    .out_blue_out   (out_blue_out),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_run_last   (out_run_last),
    .out_frame_done (out_frame_done)
  );

endmodule

// File: rtl/bb3_checker.sv
module bb3_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [bb3_pkg::CH_W-1:0]       out_red_out,
  input logic [bb3_pkg::CH_W-1:0]       out_green_out,
  input logic [bb3_pkg::CH_W-1:0]       out_blue_out,
  input logic [bb3_pkg::ROW_W-1:0]      out_row,
  input logic [bb3_pkg::COL_W-1:0]      out_col,
  input logic                           out_run_last,
  input logic                           out_frame_done
);

  // Reset starts the line store sweep and empties the output
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> (in_stall && !out_valid))
    else $error("input not stalled or output valid after reset");

  // Frame end is always the last result of its input pixel
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_done) |-> out_run_last)
    else $error("frame_done without run_last");

  // A stalled result is held
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(out_red_out) && $stable(out_green_out)
      && $stable(out_blue_out) && $stable(out_row) && $stable(out_col)
      && $stable(out_run_last) && $stable(out_frame_done)))
    else $error("stalled result changed");

endmodule

bind rgb_box_blur_3x3_unit bb3_checker u_bb3_checker (.*);

// File: test/tb_rgb_box_blur_3x3_unit.sv
module tb_rgb_box_blur_3x3_unit;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 12;

  typedef struct packed {
    logic [bb3_pkg::CH_W-1:0]  red;
    logic [bb3_pkg::CH_W-1:0]  green;
    logic [bb3_pkg::CH_W-1:0]  blue;
    logic [bb3_pkg::ROW_W-1:0] row;
    logic [bb3_pkg::COL_W-1:0] col;
    logic                      run_last;
    logic                      frame_done;
  } blur_px_t;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  logic [bb3_pkg::CH_W-1:0]       in_red_in, in_green_in, in_blue_in;
  logic                           out_valid;
  logic                           out_stall;
  logic [bb3_pkg::CH_W-1:0]       out_red_out, out_green_out, out_blue_out;
  logic [bb3_pkg::ROW_W-1:0]      out_row;
  logic [bb3_pkg::COL_W-1:0]      out_col;
  logic                           out_run_last, out_frame_done;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [bb3_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bb3_pkg::CFG_DATA_W-1:0] cfg_data;

  rgb_box_blur_3x3_unit dut (.*);

  always #4 clk = ~clk;

  // Shadow of the block's state
  logic [bb3_pkg::FW_W-1:0]  shadow_width;
  logic [bb3_pkg::FH_W-1:0]  shadow_height;
  int unsigned               pos_row, pos_col;
  logic [bb3_pkg::PIX_W-1:0] upper_line [bb3_pkg::MAX_WIDTH];
  logic [bb3_pkg::PIX_W-1:0] middle_line [bb3_pkg::MAX_WIDTH];
  logic [bb3_pkg::PIX_W-1:0] window [9];

  blur_px_t pending_px[$];
  int       fail_count = 0;
  int       pixels_sent = 0;
  int       pixels_checked = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  int       hold_cycles = 0;
  int       quiet_cycles = 0;

  function automatic logic [bb3_pkg::PIX_W-1:0] window_mean();
    logic [bb3_pkg::PIX_W-1:0] res;
    int unsigned               sum;
    res = '0;
    for (int ch = 0; ch < 3; ch++) begin
      sum = 0;
      for (int k = 0; k < 9; k++) sum += window[k][ch*bb3_pkg::CH_W +: bb3_pkg::CH_W];
      res[ch*bb3_pkg::CH_W +: bb3_pkg::CH_W] = bb3_pkg::CH_W'(sum / 9);
    end
    return res;
  endfunction

  task automatic push_px(int unsigned row, int unsigned col,
                         logic [bb3_pkg::PIX_W-1:0] px);
    blur_px_t e;
    e.red = px[23:16];
    e.green = px[15:8];
    e.blue = px[7:0];
    e.row = bb3_pkg::ROW_W'(row);
    e.col = bb3_pkg::COL_W'(col);
    e.run_last = 1'b0;
    e.frame_done = 1'b0;
    pending_px.push_back(e);
  endtask

  // Expected results for one accepted pixel
  task automatic predict_blur(logic [bb3_pkg::PIX_W-1:0] px);
    int unsigned w, h, r, c;
    int          base;
    w = shadow_width;
    h = shadow_height;
    if (w == 0) w = 1;
    if (w > bb3_pkg::MAX_WIDTH) w = bb3_pkg::MAX_WIDTH;
    if (h == 0) h = 1;
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
    end
    if (pos_row >= h) pos_row = 0;
    r = pos_row;
    c = pos_col;
    base = pending_px.size();
    for (int k = 0; k < 3; k++) begin
      window[k*3] = window[k*3+1];
      window[k*3+1] = window[k*3+2];
    end
    window[2] = upper_line[c];
    window[5] = middle_line[c];
    window[8] = px;
    upper_line[c] = middle_line[c];
    middle_line[c] = px;
    if (r >= 1) begin
      if (c >= 1) push_px(r - 1, c - 1, (r >= 2 && c >= 2) ? window_mean() : window[4]);
      if (c == w - 1) push_px(r - 1, w - 1, window[5]);
    end
    if (r == h - 1) begin
      push_px(r, c, px);
      if (c == w - 1) pending_px[$].frame_done = 1'b1;
    end
    if (pending_px.size() > base) pending_px[$].run_last = 1'b1;
    pos_col = c + 1;
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row = r + 1;
      if (pos_row >= h) pos_row = 0;
    end
  endtask

  // Send one pixel; returns at the acceptance edge with valid still high
  task automatic send_pixel(logic [bb3_pkg::CH_W-1:0] r, logic [bb3_pkg::CH_W-1:0] g,
                            logic [bb3_pkg::CH_W-1:0] b);
    while (($urandom % 100) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_red_in <= r;
    in_green_in <= g;
    in_blue_in <= b;
    do @(posedge clk); while (in_stall);
    predict_blur({r, g, b});
    pixels_sent++;
  endtask

  function automatic logic [bb3_pkg::CH_W-1:0] rand_chan();
    if ($urandom % 4 == 0) return ($urandom % 2) ? 8'hFF : 8'h00;
    return bb3_pkg::CH_W'($urandom);
  endfunction

  task automatic send_random(int n);
    for (int i = 0; i < n; i++) send_pixel(rand_chan(), rand_chan(), rand_chan());
  endtask

  // Wait until every expected result is in, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_px.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [bb3_pkg::CFG_IDX_W-1:0] idx,
                           logic [bb3_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == bb3_pkg::CFG_FRAME_WIDTH) shadow_width = val[bb3_pkg::FW_W-1:0];
    else if (idx == bb3_pkg::CFG_FRAME_HEIGHT) shadow_height = val[bb3_pkg::FH_W-1:0];
    @(posedge clk);
  endtask

  task automatic set_frame(logic [bb3_pkg::CFG_DATA_W-1:0] w,
                           logic [bb3_pkg::CFG_DATA_W-1:0] h);
    drain();
    write_reg(bb3_pkg::CFG_FRAME_WIDTH, w);
    write_reg(bb3_pkg::CFG_FRAME_HEIGHT, h);
  endtask

  // Reset geometry: row 0 of a tall frame yields nothing
  task automatic test_reset_geometry();
    send_pixel(8'hFF, 8'h00, 8'hFF);
    send_pixel(8'h00, 8'hFF, 8'h00);
    send_random(3);
  endtask

  // Degenerate sizes: every pixel is border
  task automatic test_degenerate_frames();
    set_frame(16'd1, 16'd1);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    set_frame(16'd0, 16'd0);
    send_random(2);
    set_frame(16'd2, 16'd5);
    send_random(10);
  endtask

  // Flat frames at both extremes, then a mixed one
  task automatic test_flat_frames();
    set_frame(16'd4, 16'd3);
    repeat (12) send_pixel(8'hFF, 8'hFF, 8'hFF);
    repeat (12) send_pixel(8'h00, 8'h00, 8'h00);
    send_random(12);
  endtask

  // Registers shrink under a frame in progress
  task automatic test_shrink_midframe();
    set_frame(16'd5, 16'd4);
    send_random(7);
    drain();
    write_reg(bb3_pkg::CFG_FRAME_WIDTH, 16'd2);
    send_random(1);
    drain();
    write_reg(bb3_pkg::CFG_FRAME_HEIGHT, 16'd1);
    send_random(3);
  endtask

  // Widest setting, saturated width and tallest height
  task automatic test_wide_frame();
    set_frame(16'hFFFF, 16'd2);
    send_random(6);
    set_frame(16'd2048, 16'hFFFF);
    send_random(4);
  endtask

  task automatic test_random_frames(int n_items);
    int w, h, cnt, target;
    target = pixels_sent + n_items;
    while (pixels_sent < target) begin
      w = ($urandom % 6 == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
      h = ($urandom % 6 == 0) ? $urandom_range(1, 2) : $urandom_range(3, 6);
      set_frame(bb3_pkg::CFG_DATA_W'(w), bb3_pkg::CFG_DATA_W'(h));
      cnt = ($urandom % 5 == 0) ? $urandom_range(1, w * h) : w * h;
      if (cnt > target - pixels_sent) cnt = target - pixels_sent;
      send_random(cnt);
    end
  endtask

  // Long output hold-off while the sender keeps pushing
  task automatic test_backpressure();
    set_frame(16'd3, 16'd8);
    hold_cycles = 300;
    send_random(24);
  endtask

  // Receiver
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom % 100) < recv_idle_pct;
    end
  end

  // Result checker
  always @(posedge clk) begin
    blur_px_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_px.size() == 0) begin
        $error("unexpected result row %0d col %0d", out_row, out_col);
        fail_count++;
      end else begin
        e = pending_px.pop_front();
        pixels_checked++;
        if (out_red_out !== e.red) begin
          $error("red_out exp %0d got %0d", e.red, out_red_out); fail_count++;
        end
        if (out_green_out !== e.green) begin
          $error("green_out exp %0d got %0d", e.green, out_green_out); fail_count++;
        end
        if (out_blue_out !== e.blue) begin
          $error("blue_out exp %0d got %0d", e.blue, out_blue_out); fail_count++;
        end
        if (out_row !== e.row) begin
          $error("out_row exp %0d got %0d", e.row, out_row); fail_count++;
        end
        if (out_col !== e.col) begin
          $error("out_col exp %0d got %0d", e.col, out_col); fail_count++;
        end
        if (out_run_last !== e.run_last) begin
          $error("run_last exp %0d got %0d", e.run_last, out_run_last); fail_count++;
        end
        if (out_frame_done !== e.frame_done) begin
          $error("frame_done exp %0d got %0d", e.frame_done, out_frame_done); fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL rgb_box_blur_3x3_unit");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_red_in = '0;
    in_green_in = '0;
    in_blue_in = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    shadow_width = bb3_pkg::FW_RESET;
    shadow_height = bb3_pkg::FH_RESET;
    pos_row = 0;
    pos_col = 0;
    for (int i = 0; i < bb3_pkg::MAX_WIDTH; i++) begin
      upper_line[i] = '0;
      middle_line[i] = '0;
    end
    for (int i = 0; i < 9; i++) window[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 28;
    recv_idle_pct = 85;
    test_reset_geometry();
    test_degenerate_frames();
    test_flat_frames();
    test_shrink_midframe();
    test_wide_frame();
    test_random_frames(17);
    test_backpressure();
    send_idle_pct = 85;
    recv_idle_pct = 28;
    test_random_frames(17);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_frames(17);

    drain();
    repeat (20) @(posedge clk);
    $display("Covered degenerate, flat, shrinking, wide and random frames under backpressure.");
    $display("%0d pixels sent, %0d results checked.", pixels_sent, pixels_checked);
    if (fail_count == 0)
      $display("PASS rgb_box_blur_3x3_unit");
    else
      $display("FAIL rgb_box_blur_3x3_unit");
    $finish;
  end

endmodule
